// ===== rtl/dtm_pkg.sv =====
// ----------------------------------------------------------------------------
// dtm_pkg: shared types and constants for the descriptor tolerance matcher
// Cost width, saturation limit and input opcode codes.
// ----------------------------------------------------------------------------
package dtm_pkg;
    localparam int unsigned COST_W = 16;
    localparam logic [COST_W-1:0] COST_MAX = 16'hFFFF;
    localparam logic OP_DESC = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;
    typedef logic [COST_W-1:0] t_cost;
    typedef logic [7:0] t_byte;
endpackage

// ===== rtl/descriptor_tolerance_dp_match_top.sv =====
// ----------------------------------------------------------------------------
// descriptor_tolerance_dp_match_top: descriptor tolerance match by DP
// Loads descriptor bytes and sample bytes; on the last sample runs a forward
// and backward dynamic program over memory rows and streams one cost per
// sample position, or a single error result for runs shorter than three.
// ----------------------------------------------------------------------------
// Usage: descriptor and sample loads are taken while s_axis_tready is high. A
// sample item with tlast starts matching for the n stored samples. From the
// cycle after that item, s_axis_tready stays low through matching and the
// results, longer while m_axis_tready stalls. Matching is a read/modify/write
// sweep over the row memories: each of the DESC_LEN rows and the final
// combine pass sweeps every sample and ends with one drain step. Each result
// then passes through a row memory read and an output register load. A run
// shorter than three samples gives one result with the error bit set. Costs
// saturate at 65535. The penalty register is written only while the block
// waits for input.
// s_axis_tdata = {value[7:0]} ; s_axis_tuser = op ; s_axis_tlast = last.
// m_axis_tdata = {position[5:0], cost[15:0]} padded to 24 bits;
// m_axis_tuser = error ; m_axis_tlast = final_res.
module descriptor_tolerance_dp_match_top #(
    parameter int DESC_LEN    = 7,
    parameter int MAX_SAMPLES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // value[7:0]
    input  logic        s_axis_tuser,   // op
    input  logic        s_axis_tlast,   // last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // cost[15:0], position[21:16], zero pad
    output logic        m_axis_tuser,   // error
    output logic        m_axis_tlast,   // final_res
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);
    import dtm_pkg::*;

    localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int DW = $clog2(DESC_LEN + 1);
    localparam int KW = (DESC_LEN > 1) ? $clog2(DESC_LEN) : 1;
    localparam int HALF = DESC_LEN / 2;

    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_ROW   = 3'd1;   // compute a DP row
    localparam logic [2:0] S_COMB  = 3'd2;   // combine halves
    localparam logic [2:0] S_OUT   = 3'd3;   // read one result
    localparam logic [2:0] S_OWAIT = 3'd4;   // load it into the output register
    localparam logic [2:0] S_ERR   = 3'd5;

    function automatic t_cost sadd(t_cost a, t_cost b);
        logic [COST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COST_W] ? COST_MAX : s[COST_W-1:0];
    endfunction
    function automatic t_cost mn(t_cost a, t_cost b);
        return (a < b) ? a : b;
    endfunction

    logic [7:0]    r_flaw;
    logic [2:0]    r_state;
    logic [DW-1:0] r_dcnt;
    logic [CW-1:0] r_scnt, r_n;
    logic [KW-1:0] r_k;          // descriptor element of current row
    logic          r_bwd;        // backward half, sweep runs from n-1 down
    logic          r_first;      // first row of a half (no predecessor)
    logic [AW:0]   r_j;          // sweep index, n is the drain cycle
    logic          r_buf;        // 0: previous row in row_a, 1: in row_b
    logic [CW-1:0] r_oj;         // result index

    t_byte desc_mem [DESC_LEN];
    t_byte samp_mem [MAX_SAMPLES];
    t_cost row_a [MAX_SAMPLES];
    t_cost row_b [MAX_SAMPLES];
    t_cost row_c [MAX_SAMPLES];

    // tolerance band of the current element; registered once per cycle,
    // r_k holds still for a whole row including its drain cycle
    logic [7:0] d_own, d_prv, d_nxt, avg_p, avg_n, band_lo, band_hi;
    logic [7:0] r_lo, r_hi;
    always_comb begin
        d_own = desc_mem[r_k];
        d_prv = (r_k != KW'(0)) ? desc_mem[r_k - KW'(1)] : d_own;
        d_nxt = (r_k < KW'(DESC_LEN - 1)) ? desc_mem[r_k + KW'(1)] : d_own;
        avg_p = 8'((9'(d_own) + 9'(d_prv)) >> 1);
        avg_n = 8'((9'(d_own) + 9'(d_nxt)) >> 1);
        band_lo = d_own;
        band_hi = d_own;
        if (avg_p < band_lo) band_lo = avg_p;
        if (avg_n < band_lo) band_lo = avg_n;
        if (avg_p > band_hi) band_hi = avg_p;
        if (avg_n > band_hi) band_hi = avg_n;
    end

    // sweep address: forward j, backward n-1-j, so in both halves the two
    // cells before in sweep order are the DP predecessors
    logic [AW:0]   sweep_a;
    logic [AW-1:0] rd_a;
    logic          issue;
    always_comb begin
        if (r_bwd) sweep_a = (AW+1)'(r_n) - (AW+1)'(1) - r_j;
        else       sweep_a = r_j;
    end
    assign rd_a  = (r_state == S_OUT || r_state == S_OWAIT) ? r_oj[AW-1:0]
                                                            : sweep_a[AW-1:0];
    assign issue = (r_state == S_ROW || r_state == S_COMB) && (r_j < (AW+1)'(r_n));

    // stage 0: registered memory reads
    t_cost r_rd_a, r_rd_b, r_rd_c;
    t_byte r_rd_s;
    always_ff @(posedge i_clk) begin
        r_rd_a <= row_a[rd_a];
        r_rd_b <= row_b[rd_a];
        r_rd_c <= row_c[rd_a];
        r_rd_s <= samp_mem[rd_a];
    end

    // stage 1: one cell per cycle; r_w1/r_w2 hold the previous row's values
    // of the two cells before in sweep order
    logic          r_v1;
    logic [AW-1:0] r_a1;
    logic [AW:0]   r_s1;
    t_cost         r_w1, r_w2;
    t_cost         own, err, pick, new_cost, flawc;
    assign flawc = t_cost'(r_flaw);
    always_comb begin
        own = r_buf ? r_rd_b : r_rd_a;
        if (r_rd_s < r_lo)      err = t_cost'(r_lo - r_rd_s);
        else if (r_rd_s > r_hi) err = t_cost'(r_rd_s - r_hi);
        else                    err = '0;
        pick = sadd(own, flawc);
        if (r_s1 >= (AW+1)'(1)) pick = mn(pick, r_w1);
        if (r_s1 >= (AW+1)'(2)) pick = mn(pick, sadd(r_w2, flawc));
        new_cost = r_first ? err : sadd(pick, err);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a1 <= sweep_a[AW-1:0];
        r_s1 <= r_j;
        r_w1 <= own;
        r_w2 <= r_w1;
        r_lo <= band_lo;
        r_hi <= band_hi;
    end

    // output register
    logic        r_ov;
    t_cost       r_ocost;
    logic [5:0]  r_opos;
    logic        r_olast, r_oerr;

    logic acc_in, acc_out, out_load;
    logic [CW-1:0] scnt_nxt;
    assign s_axis_tready = (r_state == S_LOAD);
    assign acc_in  = s_axis_tvalid && s_axis_tready;
    assign acc_out = m_axis_tvalid && m_axis_tready;
    assign out_load = (r_state == S_OWAIT || r_state == S_ERR) && (!r_ov || acc_out);
    assign o_cfg_ready = (r_state == S_LOAD);
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {2'b00, r_opos, r_ocost};
    assign m_axis_tuser  = r_oerr;
    assign m_axis_tlast  = r_olast;
    // sample count saturates at the store depth
    assign scnt_nxt = (r_scnt < CW'(MAX_SAMPLES)) ? r_scnt + CW'(1) : r_scnt;

    // memory writes
    always_ff @(posedge i_clk) begin
        if (acc_in && s_axis_tuser == OP_DESC)
            desc_mem[(r_dcnt == DW'(DESC_LEN)) ? KW'(0) : r_dcnt[KW-1:0]] <= s_axis_tdata;
        if (acc_in && s_axis_tuser == OP_SAMPLE && r_scnt < CW'(MAX_SAMPLES))
            samp_mem[r_scnt[AW-1:0]] <= s_axis_tdata;
        if (r_v1 && r_state == S_ROW) begin
            if (r_buf) row_a[r_a1] <= new_cost;
            else       row_b[r_a1] <= new_cost;
            if (!r_bwd && r_k == KW'(HALF))
                row_c[r_a1] <= new_cost;
        end
        if (r_v1 && r_state == S_COMB)
            row_c[r_a1] <= sadd(r_rd_c, pick);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_load) begin
            r_ov <= 1'b1;
        end else if (acc_out) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            if (r_state == S_ERR) begin
                r_ocost <= '0; r_opos <= '0; r_olast <= 1'b1; r_oerr <= 1'b1;
            end else begin
                r_ocost <= r_rd_c;
                r_opos  <= 6'(r_oj);
                r_olast <= (r_oj == r_n - CW'(1));
                r_oerr  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flaw <= 8'd16; r_state <= S_LOAD; r_dcnt <= '0; r_scnt <= '0;
            r_j <= '0; r_k <= '0; r_bwd <= 1'b0;
            r_first <= 1'b1; r_buf <= 1'b0; r_n <= '0; r_oj <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) r_flaw <= i_cfg_data;
            unique case (r_state)
                S_LOAD: if (acc_in) begin
                    if (s_axis_tuser == OP_DESC) begin
                        r_dcnt <= (r_dcnt == DW'(DESC_LEN)) ? DW'(1) : r_dcnt + DW'(1);
                    end else if (s_axis_tlast) begin
                        r_scnt <= '0; r_n <= scnt_nxt;
                        r_j <= '0; r_k <= '0; r_bwd <= 1'b0;
                        r_first <= 1'b1; r_buf <= 1'b0;
                        r_state <= (scnt_nxt < CW'(3)) ? S_ERR : S_ROW;
                    end else begin
                        r_scnt <= scnt_nxt;
                    end
                end
                S_ROW: begin
                    if (r_j == (AW+1)'(r_n)) begin
                        // drain cycle: the last cell of the row is written now
                        r_j <= '0;
                        r_buf <= ~r_buf;
                        if (!r_bwd && r_k == KW'(HALF)) begin
                            r_bwd <= 1'b1; r_first <= 1'b1;
                            r_k <= KW'(DESC_LEN - 1);
                        end else begin
                            r_first <= 1'b0;
                            if (r_bwd && r_k == KW'(HALF + 1)) r_state <= S_COMB;
                            else if (r_bwd) r_k <= r_k - KW'(1);
                            else r_k <= r_k + KW'(1);
                        end
                    end else begin
                        r_j <= r_j + (AW+1)'(1);
                    end
                end
                S_COMB: begin
                    if (r_j == (AW+1)'(r_n)) begin
                        r_j <= '0; r_oj <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_j <= r_j + (AW+1)'(1);
                    end
                end
                S_OUT: r_state <= S_OWAIT;
                S_OWAIT: if (out_load) begin
                    if (r_oj == r_n - CW'(1)) begin
                        r_state <= S_LOAD;
                    end else begin
                        r_oj <= r_oj + CW'(1);
                        r_state <= S_OUT;
                    end
                end
                S_ERR: if (out_load) begin
                    r_state <= S_LOAD;
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end
endmodule

// ===== rtl/dtm_checker.sv =====
// ----------------------------------------------------------------------------
// dtm_checker: port-level checks for the descriptor tolerance matcher
// Watches the output stream and input stall behavior.
// ----------------------------------------------------------------------------
module dtm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output item changed under stall");
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && m_axis_tdata == 24'd0)
        else $error("error item malformed");
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[23:22] == 2'b00)
        else $error("pad bits set");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input taken mid-run");
endmodule

bind descriptor_tolerance_dp_match_top dtm_checker u_dtm_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
);
